/* design/fmtg_pkg.sv */
// ----------------------------------------------------------------------------
// fmtg_pkg
// Shared widths, register codes, reset values and the sine table function of
// the FM tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fmtg_pkg;

	// configuration channel
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CARRIER_STEP   = 3'd0,
		REG_MODULATOR_STEP = 3'd1,
		REG_MOD_DEPTH      = 3'd2,
		REG_PEAK_LEVEL     = 3'd3,
		REG_BURST_LENGTH   = 3'd4
	} cfg_reg_t;

	// register and field widths
	localparam int STEP_W   = 32;
	localparam int DEPTH_W  = 24;
	localparam int LEVEL_W  = 15;
	localparam int COUNT_W  = 24;
	localparam int SAMPLE_W = 16;

	// reset values
	localparam logic [STEP_W-1:0]  RST_CARRIER_STEP   = 32'd42852281;
	localparam logic [STEP_W-1:0]  RST_MODULATOR_STEP = 32'd389566;
	localparam logic [DEPTH_W-1:0] RST_MOD_DEPTH      = 24'd260780;
	localparam logic [LEVEL_W-1:0] RST_PEAK_LEVEL     = 15'd1000;
	localparam logic [COUNT_W-1:0] RST_BURST_LENGTH   = 24'd132300;

	// sine magnitude (Q0.15, never above 32767) and serial multiplier
	localparam int MAG_W    = 15;
	localparam int FRAC_W   = 15;
	localparam int DIGIT_W  = 4;
	localparam int MPLIER_W = 24;
	localparam int N_DIGITS = MPLIER_W / DIGIT_W;
	localparam int PROD_W   = MAG_W + MPLIER_W;

	// Taylor series constants for the table build
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
		64'sd110, 64'sd156, 64'sd210};

	// First-quadrant sine magnitude for step r of a quarter of 2^qbits steps.
	// Only evaluated at elaboration to fill the table.
	function automatic logic [MAG_W-1:0] quarter_sin(int unsigned r, int unsigned qbits);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint v;
		x    = longint'((longint'(r) * HALF_PI_Q30) >>> qbits);
		x2   = (x * x) >>> 30;
		term = x;
		sum  = x;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >>> 30) / TAYLOR_DIV[k-1];
			if ((k % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > 2 * ONE_Q30) begin
			sum = 2 * ONE_Q30;
		end
		v = (sum * 32767 + (ONE_Q30 >>> 1)) >>> 30;
		if (v > 32767) begin
			v = 32767;
		end
		return v[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/fmtg_if.sv */
// ----------------------------------------------------------------------------
// fmtg_if
// Valid/ready channels of the FM tone generator: sample request, sample
// result and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmtg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface fmtg_rsp_if import fmtg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface fmtg_cfg_if import fmtg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/fmtg_sine_rom.sv */
// ----------------------------------------------------------------------------
// fmtg_sine_rom
// Quarter-wave sine table with registered read. Folds a full-turn address
// into the first quadrant and returns magnitude and sign in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtg_sine_rom import fmtg_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic [TABLE_ADDR_BITS-1:0] addr,
	output logic      [MAG_W-1:0]           mag_q,
	output logic                            neg_q
);

	localparam int QBITS = TABLE_ADDR_BITS - 2;
	localparam int QSIZE = 2 ** QBITS;
	localparam int IDX_W = TABLE_ADDR_BITS - 1;

	typedef logic [MAG_W-1:0] qtab_t [QSIZE+1];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int i = 0; i <= QSIZE; i++) begin
			t[i] = quarter_sin(i, QBITS);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	logic [1:0]       quad;
	logic [QBITS-1:0] r;
	logic [IDX_W-1:0] idx;

	assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
	assign r    = addr[QBITS-1:0];

	// odd quadrants run the table backwards
	always_comb begin
		if (quad[0]) begin
			idx = (IDX_W'(1) << QBITS) - {1'b0, r};
		end else begin
			idx = {1'b0, r};
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= QTAB[idx];
		neg_q <= quad[1];
	end

endmodule

`default_nettype wire

/* design/fmtg_serial_mult.sv */
// ----------------------------------------------------------------------------
// fmtg_serial_mult
// Digit-serial unsigned multiplier. The multiplier word shifts out one digit
// per cycle, most significant first, into a shift-add accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtg_serial_mult import fmtg_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [MAG_W-1:0]    mcand,
	input  wire logic [MPLIER_W-1:0] mplier,
	output logic                     done_q,
	output logic      [PROD_W-1:0]   prod_q
);

	localparam int CNT_W = $clog2(N_DIGITS);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MAG_W-1:0]    mcand_q;
	logic [MPLIER_W-1:0] mplier_q;
	logic [MAG_W+DIGIT_W-1:0] partial;

	assign partial = mcand_q * mplier_q[MPLIER_W-1 -: DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_DIGITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			prod_q   <= '0;
		end else if (busy_q) begin
			mplier_q <= mplier_q << DIGIT_W;
			prod_q   <= (prod_q << DIGIT_W) + PROD_W'(partial);
		end
	end

endmodule

`default_nettype wire

/* design/fm_tone_generator.sv */
// ----------------------------------------------------------------------------
// fm_tone_generator
// Two-operator FM tone generator: peak_level * cos(carrier + depth * sin(mod)).
// ----------------------------------------------------------------------------
// One request gives one signed 16-bit sample; restart clears both phases and
// the burst counter before the sample. For each sample, two products go through
// one 4-bit digit-serial multiplier (six digits each, then a done strobe), each
// preceded by a registered quarter-wave table read. The result sits in an
// output register, so a request can be taken while the previous sample still
// waits. Configuration writes are always taken; write them only while no
// sample is in flight. Writes to unknown indexes are dropped.
`default_nettype none

module fm_tone_generator import fmtg_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int PHASE_BITS      = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fmtg_req_if.sink   req,
	fmtg_rsp_if.source rsp,
	fmtg_cfg_if.sink   cfg
);

	localparam int DEV_W  = DEPTH_W + 1;
	localparam int WIDE_W = PHASE_BITS + DEV_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_ADDR,
		ST_MOD_LOAD,
		ST_MOD_MUL,
		ST_CAR_ADDR,
		ST_CAR_LOAD,
		ST_CAR_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [STEP_W-1:0]  carrier_step_q;
	logic [STEP_W-1:0]  modulator_step_q;
	logic [DEPTH_W-1:0] mod_depth_q;
	logic [LEVEL_W-1:0] peak_level_q;
	logic [COUNT_W-1:0] burst_length_q;

	logic [PHASE_BITS-1:0] carrier_phase_q;
	logic [PHASE_BITS-1:0] modulator_phase_q;
	logic [COUNT_W-1:0]    sample_index_q;
	logic                  sign_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;

	logic [TABLE_ADDR_BITS-1:0] rom_addr;
	logic [MAG_W-1:0]           rom_mag_q;
	logic                       rom_neg_q;

	logic                mult_start;
	logic [MPLIER_W-1:0] mult_mplier;
	logic                mult_done_q;
	logic [PROD_W-1:0]   prod_q;

	logic signed [DEV_W-1:0]    dev;
	logic signed [WIDE_W-1:0]   dev_wide;
	logic [WIDE_W-1:0]          dev_shifted;
	logic [PHASE_BITS-1:0]      total_phase;
	logic [TABLE_ADDR_BITS-1:0] carrier_addr;
	logic [MAG_W-1:0]           smp_mag;
	logic signed [SAMPLE_W-1:0] smp;
	logic                       last;
	logic                       out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q   <= RST_CARRIER_STEP;
			modulator_step_q <= RST_MODULATOR_STEP;
			mod_depth_q      <= RST_MOD_DEPTH;
			peak_level_q     <= RST_PEAK_LEVEL;
			burst_length_q   <= RST_BURST_LENGTH;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CARRIER_STEP:   carrier_step_q   <= cfg.data[STEP_W-1:0];
				REG_MODULATOR_STEP: modulator_step_q <= cfg.data[STEP_W-1:0];
				REG_MOD_DEPTH:      mod_depth_q      <= cfg.data[DEPTH_W-1:0];
				REG_PEAK_LEVEL:     peak_level_q     <= cfg.data[LEVEL_W-1:0];
				REG_BURST_LENGTH:   burst_length_q   <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// deviation in 2^-16 turns, truncated toward zero by sign-magnitude
	always_comb begin
		if (sign_q) begin
			dev = -$signed({1'b0, prod_q[FRAC_W +: DEPTH_W]});
		end else begin
			dev = $signed({1'b0, prod_q[FRAC_W +: DEPTH_W]});
		end
	end

	assign dev_wide     = WIDE_W'(dev);
	assign dev_shifted  = dev_wide << (PHASE_BITS - 16);
	assign total_phase  = carrier_phase_q + dev_shifted[PHASE_BITS-1:0];
	assign carrier_addr = total_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]
		+ (TABLE_ADDR_BITS'(1) << (TABLE_ADDR_BITS - 2));

	assign rom_addr = (state_q == ST_CAR_ADDR) ? carrier_addr
		: modulator_phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];

	fmtg_sine_rom #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_rom (
		.clk   (clk),
		.addr  (rom_addr),
		.mag_q (rom_mag_q),
		.neg_q (rom_neg_q)
	);

	assign mult_start  = (state_q == ST_MOD_LOAD) || (state_q == ST_CAR_LOAD);
	assign mult_mplier = (state_q == ST_MOD_LOAD) ? mod_depth_q : MPLIER_W'(peak_level_q);

	fmtg_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mult_start),
		.mcand  (rom_mag_q),
		.mplier (mult_mplier),
		.done_q (mult_done_q),
		.prod_q (prod_q)
	);

	// level times a Q0.15 magnitude stays below 2^15, so no saturation is hit
	assign smp_mag = prod_q[FRAC_W +: MAG_W];
	assign smp     = sign_q ? -$signed({1'b0, smp_mag}) : $signed({1'b0, smp_mag});
	assign last    = sample_index_q == (burst_length_q - 1'b1);

	assign out_free    = !out_valid_q || rsp.ready;
	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.sample  = sample_q;
	assign rsp.last_sample = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			carrier_phase_q   <= '0;
			modulator_phase_q <= '0;
			sample_index_q    <= '0;
			sign_q            <= 1'b0;
			out_valid_q       <= 1'b0;
			sample_q          <= '0;
			last_q            <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req.restart) begin
							carrier_phase_q   <= '0;
							modulator_phase_q <= '0;
							sample_index_q    <= '0;
						end
						state_q <= ST_MOD_ADDR;
					end
				end
				ST_MOD_ADDR: state_q <= ST_MOD_LOAD;
				ST_MOD_LOAD: begin
					sign_q  <= rom_neg_q;
					state_q <= ST_MOD_MUL;
				end
				ST_MOD_MUL: begin
					if (mult_done_q) begin
						state_q <= ST_CAR_ADDR;
					end
				end
				ST_CAR_ADDR: state_q <= ST_CAR_LOAD;
				ST_CAR_LOAD: begin
					sign_q  <= rom_neg_q;
					state_q <= ST_CAR_MUL;
				end
				ST_CAR_MUL: begin
					if (mult_done_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register has room for the transfer
					if (out_free) begin
						sample_q    <= smp;
						last_q      <= last;
						if (last) begin
							carrier_phase_q   <= '0;
							modulator_phase_q <= '0;
							sample_index_q    <= '0;
						end else begin
							carrier_phase_q   <= carrier_phase_q + PHASE_BITS'(carrier_step_q);
							modulator_phase_q <= modulator_phase_q
								+ PHASE_BITS'(modulator_step_q);
							sample_index_q    <= sample_index_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
